### rtl/rmth_pkg.sv
package rmth_pkg;

	localparam int CAPACITY   = 1024;
	localparam int HEAP_DEPTH = CAPACITY / 2 + 1;
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	localparam int TOT_W      = CNT_W + 1;
	localparam int SAMPLE_W   = 32;
	localparam int MEDIAN_W   = 33;
	localparam int COUNT_W    = 11;
	localparam int OUT_DATA_W = ((MEDIAN_W + COUNT_W + 7) / 8) * 8;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic ins;
		logic pop;
		logic desc;
	} cell_ctl_t;

endpackage

### rtl/running_median_two_heaps_core.sv
// Running median over a stream of signed 32-bit samples. The lower half of the samples is
// held in a chain of cells kept sorted largest first, the upper half in a second chain kept
// sorted smallest first, so both middle values sit in the first cell of each chain. Each
// request is accepted, the sample is inserted into a chain, the head of the larger half
// moves across if the halves differ by two, and the result register is loaded once the
// output register is free. A refused sample skips the insert and the move. The two chains
// are shared by all requests, so a new request is accepted only once the last is done.
// A new request is accepted while an earlier result still waits in the
// output register. Once CAPACITY samples are held, further samples are refused with the
// full flag set and the last median repeated.
module running_median_two_heaps_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rmth_pkg::SAMPLE_W-1:0]       s_tdata,  // sample
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rmth_pkg::OUT_DATA_W-1:0]     m_tdata,  // median_x2, count, zero fill
	output logic                                m_tuser   // full_res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INS  = 2'd1;
	localparam logic [1:0] ST_BAL  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam int TOT_W = rmth_pkg::TOT_W;
	localparam int MED_W = rmth_pkg::MEDIAN_W;
	localparam int PAD_W = rmth_pkg::OUT_DATA_W - MED_W - rmth_pkg::COUNT_W;

	logic [1:0]                      state_q;
	rmth_pkg::sample_t               x_q;
	rmth_pkg::cnt_t                  lcnt_q;
	rmth_pkg::cnt_t                  ucnt_q;
	logic                            full_q;
	logic signed [MED_W-1:0]         last_q;
	logic signed [MED_W-1:0]         out_med_q;
	logic [rmth_pkg::COUNT_W-1:0]    out_cnt_q;
	logic                            out_full_q;
	logic                            out_valid_q;

	rmth_pkg::sample_t               l_top;
	rmth_pkg::sample_t               u_top;
	rmth_pkg::cell_ctl_t             l_ctl;
	rmth_pkg::cell_ctl_t             u_ctl;
	rmth_pkg::sample_t               l_x;
	rmth_pkg::sample_t               u_x;
	logic [TOT_W-1:0]                tot;
	logic [TOT_W-1:0]                lcnt_w;
	logic [TOT_W-1:0]                ucnt_w;
	logic                            to_up;
	logic                            up_heavy;
	logic                            low_heavy;
	logic                            out_free;
	logic signed [MED_W-1:0]         med;
	logic signed [MED_W-1:0]         med_sel;

	always_comb begin
		lcnt_w    = TOT_W'(lcnt_q);
		ucnt_w    = TOT_W'(ucnt_q);
		tot       = lcnt_w + ucnt_w;
		to_up     = (ucnt_q != '0) && (x_q > u_top);
		up_heavy  = ucnt_w > lcnt_w + TOT_W'(1);
		low_heavy = lcnt_w > ucnt_w + TOT_W'(1);
		out_free  = !out_valid_q || m_tready;

		l_ctl.desc = 1'b1;
		l_ctl.ins  = ((state_q == ST_INS) && !to_up) || ((state_q == ST_BAL) && up_heavy);
		l_ctl.pop  = (state_q == ST_BAL) && low_heavy;
		u_ctl.desc = 1'b0;
		u_ctl.ins  = ((state_q == ST_INS) && to_up) || ((state_q == ST_BAL) && low_heavy);
		u_ctl.pop  = (state_q == ST_BAL) && up_heavy;
		l_x        = (state_q == ST_BAL) ? u_top : x_q;
		u_x        = (state_q == ST_BAL) ? l_top : x_q;

		if (!tot[0]) begin
			med = {l_top[rmth_pkg::SAMPLE_W-1], l_top} + {u_top[rmth_pkg::SAMPLE_W-1], u_top};
		end else if (ucnt_q > lcnt_q) begin
			med = {u_top, 1'b0};
		end else begin
			med = {l_top, 1'b0};
		end
		med_sel = full_q ? last_q : med;
	end

	rmth_chain u_lower (
		.clk (clk),
		.ctl (l_ctl),
		.x   (l_x),
		.cnt (lcnt_q),
		.top (l_top)
	);

	rmth_chain u_upper (
		.clk (clk),
		.ctl (u_ctl),
		.x   (u_x),
		.cnt (ucnt_q),
		.top (u_top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lcnt_q      <= '0;
			ucnt_q      <= '0;
			full_q      <= 1'b0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						full_q  <= tot >= TOT_W'(rmth_pkg::CAPACITY);
						state_q <= (tot >= TOT_W'(rmth_pkg::CAPACITY)) ? ST_DONE : ST_INS;
					end
				end
				ST_INS: begin
					if (to_up) begin
						ucnt_q <= ucnt_q + rmth_pkg::CNT_W'(1);
					end else begin
						lcnt_q <= lcnt_q + rmth_pkg::CNT_W'(1);
					end
					state_q <= ST_BAL;
				end
				ST_BAL: begin
					if (up_heavy) begin
						ucnt_q <= ucnt_q - rmth_pkg::CNT_W'(1);
						lcnt_q <= lcnt_q + rmth_pkg::CNT_W'(1);
					end else if (low_heavy) begin
						lcnt_q <= lcnt_q - rmth_pkg::CNT_W'(1);
						ucnt_q <= ucnt_q + rmth_pkg::CNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						last_q  <= med_sel;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && s_tvalid) begin
			x_q <= s_tdata;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_med_q  <= med_sel;
			out_cnt_q  <= rmth_pkg::COUNT_W'(tot);
			out_full_q <= full_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_cnt_q, out_med_q};
	assign m_tuser  = out_full_q;

endmodule

### rtl/rmth_cell.sv
module rmth_cell (
	input  logic                clk,
	input  rmth_pkg::cell_ctl_t ctl,
	input  rmth_pkg::sample_t   x,
	input  logic                occ,
	input  rmth_pkg::sample_t   prev_val,
	input  logic                prev_ins,
	input  rmth_pkg::sample_t   next_val,
	output rmth_pkg::sample_t   val,
	output logic                ins
);

	rmth_pkg::sample_t val_q;
	logic              ahead;

	always_comb begin
		ahead = ctl.desc ? (x > val_q) : (x < val_q);
		ins   = !occ || ahead;
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (prev_ins) begin
				val_q <= prev_val;
			end else if (ins) begin
				val_q <= x;
			end
		end else if (ctl.pop) begin
			val_q <= next_val;
		end
	end

	assign val = val_q;

endmodule

### rtl/rmth_chain.sv
module rmth_chain (
	input  logic                clk,
	input  rmth_pkg::cell_ctl_t ctl,
	input  rmth_pkg::sample_t   x,
	input  rmth_pkg::cnt_t      cnt,
	output rmth_pkg::sample_t   top
);

	localparam int N = rmth_pkg::HEAP_DEPTH;

	rmth_pkg::sample_t vals [N];
	logic              insv [N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		rmth_pkg::sample_t prev_v;
		rmth_pkg::sample_t next_v;
		logic              prev_i;
		logic              occ;

		if (i == 0) begin : g_first
			assign prev_v = x;
			assign prev_i = 1'b0;
		end else begin : g_rest
			assign prev_v = vals[i-1];
			assign prev_i = insv[i-1];
		end

		if (i == N - 1) begin : g_last
			assign next_v = vals[i];
		end else begin : g_mid
			assign next_v = vals[i+1];
		end

		assign occ = cnt > rmth_pkg::CNT_W'(i);

		rmth_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.x        (x),
			.occ      (occ),
			.prev_val (prev_v),
			.prev_ins (prev_i),
			.next_val (next_v),
			.val      (vals[i]),
			.ins      (insv[i])
		);
	end

	assign top = vals[0];

endmodule

### test/tb_running_median_two_heaps_core.sv
`timescale 1ns / 1ps

module tb_running_median_two_heaps_core;

	localparam int LOWER = 0;
	localparam int UPPER = 1;
	localparam int INT_MIN = 32'sh8000_0000;
	localparam int INT_MAX = 32'sh7fff_ffff;
	localparam int HOLD_AFTER = 600;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		rmth_pkg::sample_t sample;
		int                gap;
		bit                drain;
	} sample_req_t;

	typedef struct packed {
		logic signed [rmth_pkg::MEDIAN_W-1:0] median_x2;
		logic                                 full;
		logic [rmth_pkg::COUNT_W-1:0]         count;
	} median_res_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [rmth_pkg::SAMPLE_W-1:0]   s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [rmth_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tuser;

	sample_req_t pending[$];
	median_res_t medians_due[$];
	int          in_flight;
	int          samples_taken;
	int          errors;

	int                                   halves [2][rmth_pkg::HEAP_DEPTH];
	int                                   half_n [2];
	logic signed [rmth_pkg::MEDIAN_W-1:0] last_median;

	running_median_two_heaps_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	function automatic bit outranks(int side, int a, int b);
		return (side == LOWER) ? (a > b) : (a < b);
	endfunction

	function automatic void half_push(int side, int v);
		int i;
		int p;
		int t;
		i = half_n[side];
		if (i >= rmth_pkg::HEAP_DEPTH)
			return;
		halves[side][i] = v;
		half_n[side] = i + 1;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!outranks(side, halves[side][i], halves[side][p]))
				break;
			t = halves[side][i];
			halves[side][i] = halves[side][p];
			halves[side][p] = t;
			i = p;
		end
	endfunction

	function automatic int half_pop(int side);
		int top;
		int cnt;
		int i;
		int l;
		int r;
		int best;
		int t;
		cnt = half_n[side];
		if (cnt == 0)
			return 0;
		top = halves[side][0];
		cnt--;
		half_n[side] = cnt;
		halves[side][0] = halves[side][cnt];
		i = 0;
		while (1) begin
			l = 2 * i + 1;
			r = l + 1;
			best = i;
			if (l < cnt && outranks(side, halves[side][l], halves[side][best]))
				best = l;
			if (r < cnt && outranks(side, halves[side][r], halves[side][best]))
				best = r;
			if (best == i)
				break;
			t = halves[side][i];
			halves[side][i] = halves[side][best];
			halves[side][best] = t;
			i = best;
		end
		return top;
	endfunction

	function automatic median_res_t file_sample(int x);
		median_res_t res;
		int moved;
		int total;
		total = half_n[LOWER] + half_n[UPPER];
		res.full = 1'b0;
		if (total >= rmth_pkg::CAPACITY) begin
			res.full = 1'b1;
		end else begin
			if (half_n[UPPER] > 0 && x > halves[UPPER][0])
				half_push(UPPER, x);
			else
				half_push(LOWER, x);
			if (half_n[UPPER] > half_n[LOWER] + 1) begin
				moved = half_pop(UPPER);
				half_push(LOWER, moved);
			end else if (half_n[LOWER] > half_n[UPPER] + 1) begin
				moved = half_pop(LOWER);
				half_push(UPPER, moved);
			end
			total = half_n[LOWER] + half_n[UPPER];
			if (total % 2 == 0)
				last_median = longint'(halves[LOWER][0]) + longint'(halves[UPPER][0]);
			else if (half_n[UPPER] > half_n[LOWER])
				last_median = 2 * longint'(halves[UPPER][0]);
			else
				last_median = 2 * longint'(halves[LOWER][0]);
		end
		res.median_x2 = last_median;
		res.count = total[rmth_pkg::COUNT_W-1:0];
		return res;
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 15);
		else
			return $urandom_range(30, 80);
	endfunction

	function automatic rmth_pkg::sample_t draw_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return $urandom;
		else if (r < 75)
			return $urandom_range(0, 16) - 8;
		else if (r < 85)
			return INT_MAX - $urandom_range(0, 3);
		else if (r < 95)
			return INT_MIN + $urandom_range(0, 3);
		else
			return $urandom_range(0, 1) ? 32'h5555_5555 : 32'haaaa_aaaa;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb_running_median_two_heaps_core: errors");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : driver
		bit          fired;
		int          idle_run;
		sample_req_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			idle_run = 0;
		end else begin
			fired = s_tvalid && s_tready;
			if (s_tvalid && !fired) begin
			end else if (pending.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (idle_run < pending[0].gap ||
					(pending[0].drain && (fired || in_flight != 0))) begin
				idle_run++;
				s_tvalid <= 1'b0;
			end else begin
				req = pending.pop_front();
				s_tdata  <= req.sample;
				s_tvalid <= 1'b1;
				idle_run = 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : receiver
		int  stall_left;
		int  mode_left;
		bit  calm;
		bit  hold_done;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			mode_left  = 0;
			calm       = 1'b0;
			hold_done  = 1'b0;
		end else begin
			if (mode_left == 0) begin
				calm = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			// One long back-pressure stretch, so that the output register stays full and
			// the block refuses further requests on its input side.
			if (!hold_done && samples_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				stall_left = draw_gap();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		bit          took_in;
		bit          took_out;
		median_res_t want;
		if (!arst_n) begin
			in_flight     <= 0;
			samples_taken <= 0;
			half_n[LOWER] = 0;
			half_n[UPPER] = 0;
			last_median   = '0;
		end else begin
			took_in  = s_tvalid && s_tready;
			took_out = m_tvalid && m_tready;
			if (took_in)
				medians_due.push_back(file_sample(int'(s_tdata)));
			if (took_out) begin
				if (medians_due.size() == 0) begin
					errors++;
					$display("%0t: result with no request pending: median_x2 %0d count %0d full %0b",
						$time, $signed(m_tdata[rmth_pkg::MEDIAN_W-1:0]),
						m_tdata[rmth_pkg::MEDIAN_W +: rmth_pkg::COUNT_W], m_tuser);
				end else begin
					want = medians_due.pop_front();
					if (m_tdata[rmth_pkg::MEDIAN_W-1:0] !== want.median_x2) begin
						errors++;
						$display("%0t: median_x2 expected %0d actual %0d", $time,
							want.median_x2, $signed(m_tdata[rmth_pkg::MEDIAN_W-1:0]));
					end
					if (m_tdata[rmth_pkg::MEDIAN_W +: rmth_pkg::COUNT_W] !== want.count) begin
						errors++;
						$display("%0t: count expected %0d actual %0d", $time,
							want.count, m_tdata[rmth_pkg::MEDIAN_W +: rmth_pkg::COUNT_W]);
					end
					if (m_tuser !== want.full) begin
						errors++;
						$display("%0t: full_res expected %0b actual %0b", $time,
							want.full, m_tuser);
					end
				end
			end
			in_flight     <= in_flight + int'(took_in) - int'(took_out);
			samples_taken <= samples_taken + int'(took_in);
		end
	end

	initial begin : stimulus
		rmth_pkg::sample_t opening [];
		sample_req_t       req;
		int                k;
		opening = '{
			0, INT_MIN, INT_MIN, INT_MIN, INT_MAX, INT_MAX, INT_MAX, INT_MAX,
			INT_MAX, INT_MAX, 7, 7, 7, 7, -1, 1, INT_MAX - 1, INT_MIN + 1,
			32'h5555_5555, 32'haaaa_aaaa, 0, 0, -1
		};
		errors = 0;
		arst_n = 1'b0;
		foreach (opening[idx]) begin
			req.sample = opening[idx];
			req.gap    = 0;
			req.drain  = 1'b0;
			pending.push_back(req);
		end
		// Random requests: the store fills at its capacity and the rest are
		// refused. Every fourth block of a hundred is sent back to back.
		for (k = 0; k < 1330; k++) begin
			req.sample = draw_sample();
			req.gap    = ((k / 100) % 4 == 1) ? 0 : draw_gap();
			req.drain  = (k == 0 || k == 380);
			pending.push_back(req);
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (!(pending.size() == 0 && !s_tvalid && in_flight == 0))
			@(negedge clk);
		repeat (64) @(negedge clk);
		if (errors == 0)
			$display("tb_running_median_two_heaps_core: clean");
		else
			$display("tb_running_median_two_heaps_core: errors");
		$finish;
	end

endmodule

### sim.f
rtl/rmth_pkg.sv
rtl/rmth_cell.sv
rtl/rmth_chain.sv
rtl/running_median_two_heaps_core.sv
test/tb_running_median_two_heaps_core.sv
